@@ rtl/ks_pkg.sv @@
// Shared widths, codes, state encoding and control struct for the knapsack selector.
package ks_pkg;

  // Fixed field widths
  localparam int VALUE_W   = 16;
  localparam int WEIGHT_W  = 9;
  localparam int CAP_REG_W = 9;
  localparam int TOTAL_W   = 21;
  localparam int INDEX_W   = 5;

  // Default sizing
  localparam int MAX_ITEMS_DEF    = 32;
  localparam int MAX_CAPACITY_DEF = 511;

  // Result kinds
  localparam logic KIND_TOTAL = 1'b0;
  localparam logic KIND_ITEM  = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FETCH,
    ST_SWEEP,
    ST_DRAIN,
    ST_TOTAL,
    ST_HOLD,
    ST_TRACE_RD,
    ST_TRACE_EVAL,
    ST_FLUSH
  } ks_state_t;

  // Controller to table engine
  typedef struct packed {
    logic sweep;     // issue reads for one column of the current row
    logic first;     // current row is the first item
    logic total_rd;  // read the best value at the current column
    logic trace_rd;  // read the choice bit at current row and column
  } ks_dp_ctl_t;

endpackage

@@ rtl/ks_if.sv @@
// Valid/ready channel interfaces for item requests and result requests.
interface ks_item_if;
  import ks_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  item_value;
  logic [WEIGHT_W-1:0] item_weight;
  logic                last_item;

  modport source (output valid, item_value, item_weight, last_item, input ready);
  modport sink   (input valid, item_value, item_weight, last_item, output ready);
endinterface

interface ks_result_if;
  import ks_pkg::*;

  logic                valid;
  logic                ready;
  logic                result_kind;
  logic [TOTAL_W-1:0]  best_total;
  logic [INDEX_W-1:0]  chosen_index;
  logic [VALUE_W-1:0]  chosen_value;
  logic [WEIGHT_W-1:0] chosen_weight;
  logic                overflow;
  logic                last_result;

  modport source (output valid, result_kind, best_total, chosen_index, chosen_value,
                  chosen_weight, overflow, last_result, input ready);
  modport sink   (input valid, result_kind, best_total, chosen_index, chosen_value,
                  chosen_weight, overflow, last_result, output ready);
endinterface

@@ rtl/ks_item_store.sv @@
// Item store: one write port for loading, one registered read port.
module ks_item_store #(
  parameter int MAX_ITEMS = ks_pkg::MAX_ITEMS_DEF,
  parameter int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [IDX_W-1:0]             waddr,
  input  logic [ks_pkg::VALUE_W-1:0]   wvalue,
  input  logic [ks_pkg::WEIGHT_W-1:0]  wweight,
  input  logic                         re,
  input  logic [IDX_W-1:0]             raddr,
  output logic [ks_pkg::VALUE_W-1:0]   rvalue,
  output logic [ks_pkg::WEIGHT_W-1:0]  rweight
);
  import ks_pkg::*;

  localparam int ENTRY_W = VALUE_W + WEIGHT_W;

  logic [ENTRY_W-1:0] mem [MAX_ITEMS];

  // Write on load
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wvalue, wweight};
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      {rvalue, rweight} <= mem[raddr];
    end
  end

endmodule

@@ rtl/ks_dp_engine.sv @@
// Table engine: best-value row memory, choice-bit memory and the compare/update stage.
module ks_dp_engine #(
  parameter int MAX_ITEMS    = ks_pkg::MAX_ITEMS_DEF,
  parameter int MAX_CAPACITY = ks_pkg::MAX_CAPACITY_DEF,
  parameter int IDX_W        = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
  parameter int CAP_W        = $clog2(MAX_CAPACITY + 1),
  parameter int BEST_W       = $clog2(MAX_ITEMS * (2 ** ks_pkg::VALUE_W - 1) + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ks_pkg::ks_dp_ctl_t           ctl,
  input  logic [IDX_W-1:0]             row,
  input  logic [CAP_W-1:0]             col,
  input  logic [ks_pkg::VALUE_W-1:0]   item_v,
  input  logic [ks_pkg::WEIGHT_W-1:0]  item_w,
  output logic [BEST_W-1:0]            best_q,
  output logic                         choice_q
);
  import ks_pkg::*;

  localparam int CW_W     = (CAP_W > WEIGHT_W) ? CAP_W : WEIGHT_W;
  localparam int CH_DEPTH = 2 ** (IDX_W + CAP_W);

  logic [BEST_W-1:0] best_mem [MAX_CAPACITY + 1];
  logic              choice_mem [CH_DEPTH];

  logic              fits_i;
  logic [CAP_W-1:0]  sub_addr;
  logic [BEST_W-1:0] best_qb;

  logic              p_valid;
  logic [CAP_W-1:0]  p_col;
  logic [IDX_W-1:0]  p_row;
  logic              p_first;
  logic              p_fits;

  logic [BEST_W-1:0] take;
  logic              bit_new;
  logic [BEST_W-1:0] val_new;

  // Issue side: fit test and the address of the residual column
  assign fits_i   = CW_W'(item_w) <= CW_W'(col);
  assign sub_addr = CAP_W'(CW_W'(col) - CW_W'(item_w));

  // Row memory reads: keep port and residual port
  always_ff @(posedge clk) begin
    if (ctl.sweep || ctl.total_rd) begin
      best_q <= best_mem[col];
    end
    if (ctl.sweep && fits_i) begin
      best_qb <= best_mem[sub_addr];
    end
  end

  // Choice bit read for traceback
  always_ff @(posedge clk) begin
    if (ctl.trace_rd) begin
      choice_q <= choice_mem[{row, col}];
    end
  end

  // Pipeline register between read and write back
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= ctl.sweep;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sweep) begin
      p_col   <= col;
      p_row   <= row;
      p_first <= ctl.first;
      p_fits  <= fits_i;
    end
  end

  // Take only on a strict gain; first item taken whenever it fits
  always_comb begin
    take = BEST_W'(item_v) + best_qb;
    if (p_first) begin
      bit_new = p_fits;
      val_new = p_fits ? BEST_W'(item_v) : '0;
    end else begin
      bit_new = p_fits && (take > best_q);
      val_new = bit_new ? take : best_q;
    end
  end

  // Write back; columns descend so reads never hit the entry being written
  always_ff @(posedge clk) begin
    if (p_valid) begin
      best_mem[p_col]            <= val_new;
      choice_mem[{p_row, p_col}] <= bit_new;
    end
  end

`ifndef NO_ASSERTIONS
  a_ctl_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.sweep, ctl.total_rd, ctl.trace_rd}))
    else $error("table engine given overlapping commands");

  a_total_interlock: assert property (@(posedge clk) disable iff (rst)
    ctl.total_rd |-> !p_valid)
    else $error("total read while a write back is pending");

  a_col_descend: assert property (@(posedge clk) disable iff (rst)
    p_valid && $past(p_valid) |-> p_col + CAP_W'(1) == $past(p_col))
    else $error("write back columns not strictly descending");
`endif

endmodule

@@ rtl/knapsack_select_items.sv @@
// Top level: load control, solve sequencer, traceback and result register.
//
//  channel   dir  handshake        payload
//  items     in   valid/ready      item_value, item_weight, last_item
//  results   out  valid/ready      result_kind, best_total, chosen_index,
//                                  chosen_value, chosen_weight, overflow, last_result
//  cfg       in   cfg_we           cfg_data (capacity)
//
// Items load one per cycle. The request with last_item set starts the solve:
// n rows of a fetch state and a descending column sweep of the single row memory, then
// drain, total and hold states, read and evaluate per row of traceback, flush, plus stalls.
// items.ready is low from the closing request until the final result enters the
// result register.
// A stalled result holds traceback; reset is synchronous, no memory clearing.
module knapsack_select_items #(
  parameter int MAX_ITEMS    = ks_pkg::MAX_ITEMS_DEF,
  parameter int MAX_CAPACITY = ks_pkg::MAX_CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ks_pkg::CAP_REG_W-1:0]  cfg_data,
  ks_item_if.sink                       items,
  ks_result_if.source                   results
);
  import ks_pkg::*;

  localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CAP_W  = $clog2(MAX_CAPACITY + 1);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int BEST_W = $clog2(MAX_ITEMS * (2 ** VALUE_W - 1) + 1);
  localparam int CW_W   = (CAP_W > WEIGHT_W) ? CAP_W : WEIGHT_W;

  ks_state_t state, state_next;

  logic [CAP_REG_W-1:0] capacity;
  logic [CAP_W-1:0]     cap_lim;
  logic [CAP_W-1:0]     cap_sat;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     n_items;
  logic                 ovf;
  logic [IDX_W-1:0]     row;
  logic [CAP_W-1:0]     col;

  logic                 pend_kind;
  logic [TOTAL_W-1:0]   pend_total;
  logic [INDEX_W-1:0]   pend_index;
  logic [VALUE_W-1:0]   pend_value;
  logic [WEIGHT_W-1:0]  pend_weight;

  logic                 out_valid;
  logic                 out_kind;
  logic [TOTAL_W-1:0]   out_total;
  logic [INDEX_W-1:0]   out_index;
  logic [VALUE_W-1:0]   out_value;
  logic [WEIGHT_W-1:0]  out_weight;
  logic                 out_ovf;
  logic                 out_last;

  logic                 accept;
  logic                 store_en;
  logic                 out_free;
  logic                 row_last;
  logic                 col_zero;
  logic                 take_item;
  logic                 push;
  logic                 item_re;
  ks_dp_ctl_t           dp_ctl;

  logic [VALUE_W-1:0]   item_v;
  logic [WEIGHT_W-1:0]  item_w;
  logic [BEST_W-1:0]    best_q;
  logic                 choice_q;

  // Handshake and status terms
  assign items.ready = (state == ST_LOAD);
  assign accept      = items.valid && items.ready;
  assign store_en    = accept && (32'(count) < MAX_ITEMS);
  assign out_free    = !out_valid || results.ready;
  assign row_last    = (CNT_W'(row) + CNT_W'(1)) == n_items;
  assign col_zero    = (col == '0);
  assign take_item   = (state == ST_TRACE_EVAL) && choice_q && out_free;
  assign push        = take_item || ((state == ST_FLUSH) && out_free);
  assign cap_sat     = (32'(capacity) > MAX_CAPACITY) ? CAP_W'(MAX_CAPACITY)
                                                      : CAP_W'(capacity);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:       if (accept && items.last_item) state_next = ST_FETCH;
      ST_FETCH:      state_next = ST_SWEEP;
      ST_SWEEP: begin
        if (col_zero) state_next = row_last ? ST_DRAIN : ST_FETCH;
      end
      ST_DRAIN:      state_next = ST_TOTAL;
      ST_TOTAL:      state_next = ST_HOLD;
      ST_HOLD:       state_next = ST_TRACE_RD;
      ST_TRACE_RD:   state_next = ST_TRACE_EVAL;
      ST_TRACE_EVAL: begin
        if (!(choice_q && !out_free)) begin
          state_next = (row == '0) ? ST_FLUSH : ST_TRACE_RD;
        end
      end
      ST_FLUSH:      if (out_free) state_next = ST_LOAD;
      default:       state_next = ST_LOAD;
    endcase
  end

  // Memory commands per state
  always_comb begin
    dp_ctl          = '0;
    item_re         = 1'b0;
    case (state)
      ST_FETCH:    item_re = 1'b1;
      ST_SWEEP: begin
        dp_ctl.sweep = 1'b1;
        dp_ctl.first = (row == '0);
      end
      ST_TOTAL:    dp_ctl.total_rd = 1'b1;
      ST_TRACE_RD: begin
        item_re         = 1'b1;
        dp_ctl.trace_rd = 1'b1;
      end
      default: begin
        dp_ctl  = '0;
        item_re = 1'b0;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      ovf      <= 1'b0;
      capacity <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (store_en) begin
        count <= count + CNT_W'(1);
      end else if (accept) begin
        ovf <= 1'b1;
      end
      if ((state == ST_FLUSH) && out_free) begin
        count <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  // Solve and traceback indices, pending result
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        if (accept && items.last_item) begin
          n_items <= store_en ? count + CNT_W'(1) : count;
          cap_lim <= cap_sat;
          col     <= cap_sat;
          row     <= '0;
        end
      end
      ST_SWEEP: begin
        if (col_zero) begin
          col <= cap_lim;
          if (!row_last) row <= row + IDX_W'(1);
        end else begin
          col <= col - CAP_W'(1);
        end
      end
      ST_HOLD: begin
        pend_kind   <= KIND_TOTAL;
        pend_total  <= TOTAL_W'(best_q);
        pend_index  <= '0;
        pend_value  <= '0;
        pend_weight <= '0;
      end
      ST_TRACE_EVAL: begin
        if (take_item) begin
          pend_kind   <= KIND_ITEM;
          pend_total  <= '0;
          pend_index  <= INDEX_W'(row);
          pend_value  <= item_v;
          pend_weight <= item_w;
          col         <= CAP_W'(CW_W'(col) - CW_W'(item_w));
        end
        if (!(choice_q && !out_free) && (row != '0)) begin
          row <= row - IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind   <= pend_kind;
      out_total  <= pend_total;
      out_index  <= pend_index;
      out_value  <= pend_value;
      out_weight <= pend_weight;
      out_ovf    <= ovf;
      out_last   <= (state == ST_FLUSH);
    end
  end

  assign results.valid         = out_valid;
  assign results.result_kind   = out_kind;
  assign results.best_total    = out_total;
  assign results.chosen_index  = out_index;
  assign results.chosen_value  = out_value;
  assign results.chosen_weight = out_weight;
  assign results.overflow      = out_ovf;
  assign results.last_result   = out_last;

  // Item memory
  ks_item_store #(
    .MAX_ITEMS (MAX_ITEMS),
    .IDX_W     (IDX_W)
  ) u_items (
    .clk     (clk),
    .we      (store_en),
    .waddr   (IDX_W'(count)),
    .wvalue  (items.item_value),
    .wweight (items.item_weight),
    .re      (item_re),
    .raddr   (row),
    .rvalue  (item_v),
    .rweight (item_w)
  );

  // Table memories and update stage
  ks_dp_engine #(
    .MAX_ITEMS    (MAX_ITEMS),
    .MAX_CAPACITY (MAX_CAPACITY),
    .IDX_W        (IDX_W),
    .CAP_W        (CAP_W),
    .BEST_W       (BEST_W)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .ctl      (dp_ctl),
    .row      (row),
    .col      (col),
    .item_v   (item_v),
    .item_w   (item_w),
    .best_q   (best_q),
    .choice_q (choice_q)
  );

`ifndef NO_ASSERTIONS
  a_close_blocks: assert property (@(posedge clk) disable iff (rst)
    accept && items.last_item |=> !items.ready)
    else $error("items still taken after the closing request");

  a_chosen_fits: assert property (@(posedge clk) disable iff (rst)
    take_item |-> CW_W'(item_w) <= CW_W'(col))
    else $error("chosen item heavier than remaining capacity");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) && out_free |=> (state == ST_LOAD) && (count == '0) && !ovf)
    else $error("set state not cleared after final result");
`endif

endmodule
